/* hw/rtl/bms_pkg.sv */
// Shared types, constants and register map of the bracket minimum search block.
package bms_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_ADDR_BITS = 4;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_GOLD   = 4'h0;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_GROWTH = 4'h4;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_FLOOR  = 4'h8;

  localparam logic [17:0] GOLD_RST   = 18'd106039;
  localparam logic [30:0] GROWTH_RST = 31'd6553600;
  localparam logic [15:0] FLOOR_RST  = 16'd1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] start_a;
    logic signed [31:0] start_b;
    logic signed [31:0] f_value;
  } in_word_t;

  typedef struct packed {
    logic               done_res;
    logic signed [31:0] eval_x;
    logic signed [31:0] a_x;
    logic signed [31:0] a_f;
    logic signed [31:0] b_x;
    logic signed [31:0] b_f;
    logic signed [31:0] c_x;
    logic signed [31:0] c_f;
  } out_word_t;

  // search phase: which evaluation the block waits for
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FA,
    PH_FB,
    PH_FC,
    PH_INNER,
    PH_OUTER,
    PH_SHIFT
  } phase_t;

  // sequencer steps of the shared multiplier and divider
  typedef enum logic [3:0] {
    CS_WAIT,
    CS_ADV,
    CS_RMUL,
    CS_QMUL,
    CS_P1MUL,
    CS_P2MUL,
    CS_NUMDEN,
    CS_LIMCAP,
    CS_DIVWAIT,
    CS_CLASS,
    CS_GMUL,
    CS_GADD
  } ctl_state_t;

endpackage

/* hw/rtl/bms_mul.sv */
// Shared fixed-point multiplier with truncation and saturation, registered output.
module bms_mul #(
  parameter int W  = bms_pkg::WORD_BITS_DEF,
  parameter int F  = bms_pkg::FRAC_BITS_DEF,
  parameter int MW = (W > 32) ? W : 32
) (
  input  logic                clk,
  input  logic signed [MW-1:0] x,
  input  logic signed [MW-1:0] y,
  output logic signed [W-1:0]  p
);

  localparam logic [2*MW-1:0] HALF = (2*MW)'(1) << (W - 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [MW-1:0]     mx, my;
  logic [2*MW-1:0]   prod, sh;
  logic              neg;
  logic signed [W-1:0] p_nxt;

  always_comb begin
    mx    = x[MW-1] ? (~x + 1'b1) : x;
    my    = y[MW-1] ? (~y + 1'b1) : y;
    neg   = x[MW-1] ^ y[MW-1];
    prod  = (2*MW)'(mx) * (2*MW)'(my);
    sh    = prod >> F;
    if (neg) begin
      p_nxt = (sh > HALF) ? WMIN : W'(~sh[W-1:0] + 1'b1);
    end else begin
      p_nxt = (sh > HALF - 1'b1) ? WMAX : sh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    p <= p_nxt;
  end

endmodule

/* hw/rtl/bms_div.sv */
// Serial restoring divider for the parabola step, one quotient bit per cycle.
module bms_div #(
  parameter int W = bms_pkg::WORD_BITS_DEF,
  parameter int F = bms_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [W-1:0]        num_mag,
  input  logic [W-1:0]        den_mag,
  input  logic                neg,
  output logic                done,
  output logic signed [W-1:0] quot
);

  localparam int N  = W + F - 1;
  localparam int CW = $clog2(N + 1);
  localparam logic [N-1:0] HALF = N'(1) << (W - 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [N-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [W:0]    sh;
  logic          qbit;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    sh       = {rem_r, acc_r[N-1]};
    qbit     = (sh >= {1'b0, den_r});
    if (start) begin
      // dividend is the numerator shifted up by F-1: quotient of num over twice den
      acc_nxt  = {num_mag, {(F-1){1'b0}}};
      rem_nxt  = '0;
      den_nxt  = den_mag;
      neg_nxt  = neg;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = qbit ? W'(sh - {1'b0, den_r}) : sh[W-1:0];
      acc_nxt = {acc_r[N-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      quot = (acc_r > HALF) ? WMIN : W'(~acc_r[W-1:0] + 1'b1);
    end else begin
      quot = (acc_r > HALF - 1'b1) ? WMAX : acc_r[W-1:0];
    end
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

endmodule

/* hw/rtl/bracket_minimum_search.sv */
// Top level of the bracket minimum search sequencer.
// Brackets a minimum of a function of one variable. A start word (op 0) gives two
// abscissas; every later word (op 1) carries the function value at the point the
// block last asked for, and each accepted word yields exactly one result word (a value
// word while no search runs yields none): either the next point to evaluate (done_res 0,
// eval_x) or the finished bracket a, b, c with values (done_res 1). Arithmetic is signed
// fixed point, WORD_BITS wide with FRAC_BITS fraction bits (Q16.16 by default),
// saturating, products and quotients rounded toward zero. A start word or the first
// value is answered directly; the second value takes one golden step through the
// shared multiplier; a value that triggers parabolic extrapolation waits on the serial
// divider, which yields one quotient bit per cycle, then on the golden fallback if that
// follows. The input is stalled while a word is in progress and while a result waits
// to be taken.
module bracket_minimum_search #(
  parameter int WORD_BITS = bms_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = bms_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  bms_pkg::in_word_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output bms_pkg::out_word_t                    out_data,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [bms_pkg::CFG_ADDR_BITS-1:0]     cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int W  = WORD_BITS;
  localparam int MW = (W > 32) ? W : 32;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // saturating add and subtract on the word
  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) begin
      return s[W] ? WMIN : WMAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} - {y[W-1], y};
    if (s[W] != s[W-1]) begin
      return s[W] ? WMIN : WMAX;
    end
    return s[W-1:0];
  endfunction

  // sign-extend a 32-bit field and clamp it to the word
  function automatic logic signed [W-1:0] from_in(input logic signed [31:0] v);
    logic signed [63:0] e, mx, mn;
    e  = 64'(v);
    mx = 64'(WMAX);
    mn = 64'(WMIN);
    if (e > mx) begin
      return WMAX;
    end
    if (e < mn) begin
      return WMIN;
    end
    return W'(e);
  endfunction

  // low 32 bits of the sign-extended word
  function automatic logic signed [31:0] to_out(input logic signed [W-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[31:0];
  endfunction

  // configuration registers
  logic [17:0] gold_r;
  logic [30:0] growth_r;
  logic [15:0] floor_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr)
      bms_pkg::ADDR_GOLD:   cfg_prdata = {14'd0, gold_r};
      bms_pkg::ADDR_GROWTH: cfg_prdata = {1'b0, growth_r};
      bms_pkg::ADDR_FLOOR:  cfg_prdata = {16'd0, floor_r};
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gold_r   <= bms_pkg::GOLD_RST;
      growth_r <= bms_pkg::GROWTH_RST;
      floor_r  <= bms_pkg::FLOOR_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        bms_pkg::ADDR_GOLD:   gold_r   <= cfg_pwdata[17:0];
        bms_pkg::ADDR_GROWTH: growth_r <= cfg_pwdata[30:0];
        bms_pkg::ADDR_FLOOR:  floor_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // control state
  bms_pkg::ctl_state_t state_r, state_nxt;
  bms_pkg::phase_t     phase_r, phase_nxt;
  logic                gold_c_r, gold_c_nxt;
  logic                out_valid_r, out_valid_nxt;
  bms_pkg::out_word_t  out_data_r, out_data_nxt;

  // bracket points and intermediate terms
  logic signed [W-1:0] ax_r, ax_nxt, af_r, af_nxt;
  logic signed [W-1:0] bx_r, bx_nxt, bf_r, bf_nxt;
  logic signed [W-1:0] cx_r, cx_nxt, cf_r, cf_nxt;
  logic signed [W-1:0] trial_r, trial_nxt;
  logic signed [W-1:0] r_r, r_nxt, q_r, q_nxt, p1_r, p1_nxt, lim_r, lim_nxt;

  // shared units
  logic signed [MW-1:0] mul_x, mul_y;
  logic signed [W-1:0]  mul_p;
  logic                 div_start, div_neg, div_done;
  logic [W-1:0]         div_num, div_den;
  logic signed [W-1:0]  div_q;

  bms_mul #(.W(W), .F(FRAC_BITS), .MW(MW)) u_mul (
    .clk (clk),
    .x   (mul_x),
    .y   (mul_y),
    .p   (mul_p)
  );

  bms_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (div_num),
    .den_mag (div_den),
    .neg     (div_neg),
    .done    (div_done),
    .quot    (div_q)
  );

  logic                in_acc;
  logic signed [W-1:0] f_in;
  logic signed [W-1:0] xu;
  logic                cl_inner, cl_outer, cl_lim;

  assign in_stall  = !((state_r == bms_pkg::CS_WAIT) && !out_valid_r);
  assign in_acc    = in_valid && !in_stall;
  assign f_in      = from_in(in_data.f_value);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // parabola point and its placement
  always_comb begin
    xu       = sat_sub(bx_r, div_q);
    cl_inner = (bx_r > xu && xu > cx_r) || (bx_r < xu && xu < cx_r);
    cl_outer = (cx_r > xu && xu > lim_r) || (cx_r < xu && xu < lim_r);
    cl_lim   = (xu == lim_r) || (lim_r == cx_r) ||
               (xu > lim_r && lim_r > cx_r) || (xu < lim_r && lim_r < cx_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bms_pkg::CS_WAIT: begin
        if (in_acc && in_data.op == bms_pkg::OP_VALUE) begin
          case (phase_r)
            bms_pkg::PH_FB: state_nxt = bms_pkg::CS_GMUL;
            bms_pkg::PH_FC: state_nxt = bms_pkg::CS_ADV;
            bms_pkg::PH_SHIFT: state_nxt = bms_pkg::CS_ADV;
            bms_pkg::PH_INNER: begin
              if (!(f_in < cf_r) && !(f_in > bf_r)) begin
                state_nxt = bms_pkg::CS_GMUL;
              end
            end
            bms_pkg::PH_OUTER: begin
              state_nxt = (f_in < cf_r) ? bms_pkg::CS_GMUL : bms_pkg::CS_ADV;
            end
            default: state_nxt = bms_pkg::CS_WAIT;
          endcase
        end
      end
      bms_pkg::CS_ADV:    state_nxt = (bf_r > cf_r) ? bms_pkg::CS_RMUL : bms_pkg::CS_WAIT;
      bms_pkg::CS_RMUL:   state_nxt = bms_pkg::CS_QMUL;
      bms_pkg::CS_QMUL:   state_nxt = bms_pkg::CS_P1MUL;
      bms_pkg::CS_P1MUL:  state_nxt = bms_pkg::CS_P2MUL;
      bms_pkg::CS_P2MUL:  state_nxt = bms_pkg::CS_NUMDEN;
      bms_pkg::CS_NUMDEN: state_nxt = bms_pkg::CS_LIMCAP;
      bms_pkg::CS_LIMCAP: state_nxt = bms_pkg::CS_DIVWAIT;
      bms_pkg::CS_DIVWAIT: begin
        if (div_done) begin
          state_nxt = bms_pkg::CS_CLASS;
        end
      end
      bms_pkg::CS_CLASS: begin
        state_nxt = (cl_inner || cl_outer || cl_lim) ? bms_pkg::CS_WAIT : bms_pkg::CS_GMUL;
      end
      bms_pkg::CS_GMUL: state_nxt = bms_pkg::CS_GADD;
      bms_pkg::CS_GADD: state_nxt = bms_pkg::CS_WAIT;
      default:          state_nxt = bms_pkg::CS_WAIT;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic                emit_ev, emit_dn;
    logic signed [W-1:0] ev_x, num, den, cc, bb, gres;
    logic [W-1:0]        nmag, dmag, flo;

    phase_nxt  = phase_r;
    gold_c_nxt = gold_c_r;
    ax_nxt = ax_r;  af_nxt = af_r;
    bx_nxt = bx_r;  bf_nxt = bf_r;
    cx_nxt = cx_r;  cf_nxt = cf_r;
    trial_nxt = trial_r;
    r_nxt = r_r;  q_nxt = q_r;  p1_nxt = p1_r;  lim_nxt = lim_r;
    mul_x = '0;
    mul_y = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_neg   = 1'b0;
    emit_ev = 1'b0;
    emit_dn = 1'b0;
    ev_x    = '0;
    num = '0;  den = '0;  nmag = '0;  dmag = '0;
    flo  = (floor_r == 16'd0) ? W'(1) : W'(floor_r);
    cc   = gold_c_r ? bx_r : cx_r;
    bb   = gold_c_r ? ax_r : bx_r;
    gres = sat_add(cc, mul_p);
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      bms_pkg::CS_WAIT: begin
        if (in_acc) begin
          if (in_data.op == bms_pkg::OP_START) begin
            // restart: drop any search in flight
            ax_nxt = from_in(in_data.start_a);
            bx_nxt = from_in(in_data.start_b);
            af_nxt = '0;  bf_nxt = '0;  cx_nxt = '0;  cf_nxt = '0;
            trial_nxt = '0;
            phase_nxt = bms_pkg::PH_FA;
            emit_ev = 1'b1;
            ev_x    = from_in(in_data.start_a);
          end else begin
            case (phase_r)
              bms_pkg::PH_FA: begin
                af_nxt    = f_in;
                phase_nxt = bms_pkg::PH_FB;
                emit_ev   = 1'b1;
                ev_x      = bx_r;
              end
              bms_pkg::PH_FB: begin
                // orient downhill: a is the higher point
                if (f_in > af_r) begin
                  ax_nxt = bx_r;  af_nxt = f_in;
                  bx_nxt = ax_r;  bf_nxt = af_r;
                end else begin
                  bf_nxt = f_in;
                end
                phase_nxt  = bms_pkg::PH_FC;
                gold_c_nxt = 1'b1;
              end
              bms_pkg::PH_FC: begin
                cf_nxt = f_in;
              end
              bms_pkg::PH_INNER: begin
                if (f_in < cf_r) begin
                  ax_nxt = bx_r;     af_nxt = bf_r;
                  bx_nxt = trial_r;  bf_nxt = f_in;
                  emit_dn = 1'b1;
                end else if (f_in > bf_r) begin
                  cx_nxt = trial_r;  cf_nxt = f_in;
                  emit_dn = 1'b1;
                end else begin
                  phase_nxt  = bms_pkg::PH_SHIFT;
                  gold_c_nxt = 1'b0;
                end
              end
              bms_pkg::PH_OUTER: begin
                if (f_in < cf_r) begin
                  // shift b and c first; golden step then uses the new pair
                  bx_nxt = cx_r;     bf_nxt = cf_r;
                  cx_nxt = trial_r;  cf_nxt = f_in;
                  phase_nxt  = bms_pkg::PH_SHIFT;
                  gold_c_nxt = 1'b0;
                end else begin
                  ax_nxt = bx_r;     af_nxt = bf_r;
                  bx_nxt = cx_r;     bf_nxt = cf_r;
                  cx_nxt = trial_r;  cf_nxt = f_in;
                end
              end
              bms_pkg::PH_SHIFT: begin
                ax_nxt = bx_r;     af_nxt = bf_r;
                bx_nxt = cx_r;     bf_nxt = cf_r;
                cx_nxt = trial_r;  cf_nxt = f_in;
              end
              default: ;
            endcase
          end
        end
      end
      bms_pkg::CS_ADV: begin
        if (!(bf_r > cf_r)) begin
          emit_dn = 1'b1;
        end
      end
      bms_pkg::CS_RMUL: begin
        mul_x = MW'(sat_sub(bx_r, ax_r));
        mul_y = MW'(sat_sub(bf_r, cf_r));
      end
      bms_pkg::CS_QMUL: begin
        r_nxt = mul_p;
        mul_x = MW'(sat_sub(bx_r, cx_r));
        mul_y = MW'(sat_sub(bf_r, af_r));
      end
      bms_pkg::CS_P1MUL: begin
        q_nxt = mul_p;
        mul_x = MW'(sat_sub(bx_r, cx_r));
        mul_y = MW'(mul_p);
      end
      bms_pkg::CS_P2MUL: begin
        p1_nxt = mul_p;
        mul_x  = MW'(sat_sub(bx_r, ax_r));
        mul_y  = MW'(r_r);
      end
      bms_pkg::CS_NUMDEN: begin
        num  = sat_sub(p1_r, mul_p);
        den  = sat_sub(q_r, r_r);
        nmag = num[W-1] ? (~num + 1'b1) : num;
        dmag = den[W-1] ? (~den + 1'b1) : den;
        // floor the denominator magnitude
        div_den   = (dmag < flo) ? flo : dmag;
        div_num   = nmag;
        div_neg   = num[W-1] ^ den[W-1];
        div_start = 1'b1;
        mul_x = MW'($signed({1'b0, growth_r}));
        mul_y = MW'(sat_sub(cx_r, bx_r));
      end
      bms_pkg::CS_LIMCAP: begin
        lim_nxt = sat_add(bx_r, mul_p);
      end
      bms_pkg::CS_DIVWAIT: ;
      bms_pkg::CS_CLASS: begin
        if (cl_inner) begin
          trial_nxt = xu;
          phase_nxt = bms_pkg::PH_INNER;
          emit_ev   = 1'b1;
          ev_x      = xu;
        end else if (cl_outer) begin
          trial_nxt = xu;
          phase_nxt = bms_pkg::PH_OUTER;
          emit_ev   = 1'b1;
          ev_x      = xu;
        end else if (cl_lim) begin
          trial_nxt = lim_r;
          phase_nxt = bms_pkg::PH_SHIFT;
          emit_ev   = 1'b1;
          ev_x      = lim_r;
        end else begin
          phase_nxt  = bms_pkg::PH_SHIFT;
          gold_c_nxt = 1'b0;
        end
      end
      bms_pkg::CS_GMUL: begin
        mul_x = MW'($signed({1'b0, gold_r}));
        mul_y = MW'(sat_sub(cc, bb));
      end
      bms_pkg::CS_GADD: begin
        if (gold_c_r) begin
          cx_nxt = gres;
        end else begin
          trial_nxt = gres;
        end
        emit_ev = 1'b1;
        ev_x    = gres;
      end
      default: ;
    endcase

    if (emit_ev) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt.eval_x = to_out(ev_x);
    end
    if (emit_dn) begin
      phase_nxt     = bms_pkg::PH_IDLE;
      out_valid_nxt = 1'b1;
      out_data_nxt.done_res = 1'b1;
      out_data_nxt.eval_x   = '0;
      out_data_nxt.a_x = to_out(ax_nxt);
      out_data_nxt.a_f = to_out(af_nxt);
      out_data_nxt.b_x = to_out(bx_nxt);
      out_data_nxt.b_f = to_out(bf_nxt);
      out_data_nxt.c_x = to_out(cx_nxt);
      out_data_nxt.c_f = to_out(cf_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bms_pkg::CS_WAIT;
      phase_r     <= bms_pkg::PH_IDLE;
      gold_c_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      gold_c_r    <= gold_c_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    ax_r <= ax_nxt;  af_r <= af_nxt;
    bx_r <= bx_nxt;  bf_r <= bf_nxt;
    cx_r <= cx_nxt;  cf_r <= cf_nxt;
    trial_r <= trial_nxt;
    r_r  <= r_nxt;
    q_r  <= q_nxt;
    p1_r <= p1_nxt;
    lim_r <= lim_nxt;
  end

endmodule

/* hw/rtl/bms_chk.sv */
// Port-level checker for the bracket minimum search block and its bind.
module bms_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input bms_pkg::in_word_t                 in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input bms_pkg::out_word_t                out_data
);

  // a start word always answers with an evaluation request next cycle
  a_start_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == bms_pkg::OP_START)
      |=> (out_valid && !out_data.done_res))
    else $error("start word did not produce an evaluation request");

  // hold the input while a result waits
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.done_res) |-> (out_data.eval_x == 32'sd0))
    else $error("finished bracket carries an evaluation point");

  a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.done_res)
      |-> (out_data.a_x == 32'sd0 && out_data.b_x == 32'sd0 && out_data.c_x == 32'sd0 &&
           out_data.a_f == 32'sd0 && out_data.b_f == 32'sd0 && out_data.c_f == 32'sd0))
    else $error("evaluation request carries bracket fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind bracket_minimum_search bms_chk u_bms_chk (.*);

/* tb/bracket_minimum_search_test.sv */
// Testbench for the bracket minimum search sequencer: drives searches, predicts and checks results.
`timescale 1ns / 100ps

module bracket_minimum_search_test;
  import bms_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 20000;   // cycles without any handshake
  localparam int SETTLE = 120;          // longest word is well under this

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  bracket_minimum_search dut (.*);

  // ---- saturating Q16.16 arithmetic, values held in longint ----
  function automatic longint clamp_word(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint sat_add(longint x, longint y);
    return clamp_word(x + y);
  endfunction

  function automatic longint sat_sub(longint x, longint y);
    return clamp_word(x - y);
  endfunction

  // apply sign to a truncated magnitude and saturate
  function automatic longint signed_mag(longint m, bit neg);
    if (neg) return (m > 64'sd2147483648) ? WMIN : -m;
    return (m > WMAX) ? WMAX : m;
  endfunction

  function automatic longint fx_mul(longint x, longint y);
    longint ux, uy;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    return signed_mag((ux * uy) >>> 16, (x < 0) != (y < 0));
  endfunction

  // num / (2 * den) in Q form, den magnitude already floored
  function automatic longint fx_half_div(longint nm, longint dm, bit neg);
    return signed_mag((nm <<< 15) / dm, neg);
  endfunction

  // ---- scoreboard: predicts the sequencer and checks its result words ----
  class bracket_scoreboard;
    phase_t ph;
    longint ax, af, bx, bf, cx, cf, tx;
    longint gold, growth, dfloor;
    out_word_t pending[$];
    longint next_x;
    int errors, words_in, words_out, brackets;

    function void clear_state();
      ph = PH_IDLE;
      ax = 0; af = 0; bx = 0; bf = 0; cx = 0; cf = 0; tx = 0;
      next_x = 0;
    endfunction

    function longint golden_from(longint c, longint b);
      return sat_add(c, fx_mul(gold, sat_sub(c, b)));
    endfunction

    function void push_eval(longint x);
      out_word_t o;
      o = '0;
      o.eval_x = x[31:0];
      next_x = x;
      pending.push_back(o);
    endfunction

    function void push_bracket();
      out_word_t o;
      o = '0;
      o.done_res = 1'b1;
      o.a_x = ax[31:0]; o.a_f = af[31:0];
      o.b_x = bx[31:0]; o.b_f = bf[31:0];
      o.c_x = cx[31:0]; o.c_f = cf[31:0];
      ph = PH_IDLE;
      brackets++;
      pending.push_back(o);
    endfunction

    function void rotate_in(longint x, longint f);
      ax = bx; af = bf;
      bx = cx; bf = cf;
      cx = x; cf = f;
    endfunction

    // bracket test, then one parabolic extrapolation step
    function void step_parabola();
      longint d1, d2, r, q, num, den, xu, lim, dm, fl;
      if (!(bf > cf)) begin
        push_bracket();
        return;
      end
      d1 = sat_sub(bx, ax);
      d2 = sat_sub(bx, cx);
      r = fx_mul(d1, sat_sub(bf, cf));
      q = fx_mul(d2, sat_sub(bf, af));
      num = sat_sub(fx_mul(d2, q), fx_mul(d1, r));
      den = sat_sub(q, r);
      fl = (dfloor == 0) ? 1 : dfloor;
      dm = (den < 0) ? -den : den;
      if (dm < fl) dm = fl;
      xu = sat_sub(bx, fx_half_div((num < 0) ? -num : num, dm, (num < 0) != (den < 0)));
      lim = sat_add(bx, fx_mul(growth, sat_sub(cx, bx)));
      if ((bx > xu && xu > cx) || (bx < xu && xu < cx)) begin
        ph = PH_INNER;
      end else if ((cx > xu && xu > lim) || (cx < xu && xu < lim)) begin
        ph = PH_OUTER;
      end else if (xu == lim || lim == cx || (xu > lim && lim > cx) ||
                   (xu < lim && lim < cx)) begin
        xu = lim;
        ph = PH_SHIFT;
      end else begin
        xu = golden_from(cx, bx);
        ph = PH_SHIFT;
      end
      tx = xu;
      push_eval(xu);
    endfunction

    // note an accepted input word and queue the result it causes
    function void note_word(in_word_t w);
      longint f, t;
      words_in++;
      if (w.op == OP_START) begin
        clear_state();
        ax = longint'(w.start_a);
        bx = longint'(w.start_b);
        ph = PH_FA;
        push_eval(ax);
        return;
      end
      f = longint'(w.f_value);
      case (ph)
        PH_FA: begin
          af = f;
          ph = PH_FB;
          push_eval(bx);
        end
        PH_FB: begin
          bf = f;
          if (bf > af) begin
            t = ax; ax = bx; bx = t;
            t = af; af = bf; bf = t;
          end
          cx = golden_from(bx, ax);
          ph = PH_FC;
          push_eval(cx);
        end
        PH_FC: begin
          cf = f;
          step_parabola();
        end
        PH_INNER: begin
          if (f < cf) begin
            ax = bx; af = bf;
            bx = tx; bf = f;
            push_bracket();
          end else if (f > bf) begin
            cx = tx; cf = f;
            push_bracket();
          end else begin
            tx = golden_from(cx, bx);
            ph = PH_SHIFT;
            push_eval(tx);
          end
        end
        PH_OUTER: begin
          if (f < cf) begin
            bx = cx; bf = cf;
            cx = tx; cf = f;
            tx = golden_from(cx, bx);
            ph = PH_SHIFT;
            push_eval(tx);
          end else begin
            rotate_in(tx, f);
            step_parabola();
          end
        end
        PH_SHIFT: begin
          rotate_in(tx, f);
          step_parabola();
        end
        default: ;  // stray value while idle: nothing comes back
      endcase
    endfunction

    function void compare(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: mismatch %s expected %h actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    // check one accepted result word against the oldest expectation
    function void check_word(out_word_t o);
      out_word_t e;
      words_out++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, o);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare("done_res", e.done_res, o.done_res);
      compare("eval_x", e.eval_x, o.eval_x);
      compare("a_x", e.a_x, o.a_x);
      compare("a_f", e.a_f, o.a_f);
      compare("b_x", e.b_x, o.b_x);
      compare("b_f", e.b_f, o.b_f);
      compare("c_x", e.c_x, o.c_x);
      compare("c_f", e.c_f, o.c_f);
    endfunction
  endclass

  bracket_scoreboard sb;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---- receiver: stall pattern switched per phase ----
  int stall_pct = 0;
  int stall_run = 0;

  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      // occasionally hold for a longer stretch
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(2, 15) : 0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---- result monitor and watchdog ----
  int quiet = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall)))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---- sender: bursts with random gaps ----
  int burst_left = 0;
  bit gaps_on = 1'b1;

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  // write one register: setup cycle, then access cycle
  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr, input longint value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value[31:0];
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (addr)
      ADDR_GOLD:   sb.gold = value & 64'h3FFFF;
      ADDR_GROWTH: sb.growth = value & 64'h7FFFFFFF;
      ADDR_FLOOR:  sb.dfloor = value & 64'hFFFF;
      default: ;
    endcase
  endtask

  // drain the block before touching the registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_word_t start_word(longint a, longint b);
    in_word_t w;
    w = '0;
    w.op = OP_START;
    w.start_a = a[31:0];
    w.start_b = b[31:0];
    w.f_value = $urandom();
    return w;
  endfunction

  function automatic in_word_t value_word(longint f);
    in_word_t w;
    w = '0;
    w.op = OP_VALUE;
    w.start_a = $urandom();
    w.start_b = $urandom();
    w.f_value = f[31:0];
    return w;
  endfunction

  // test function at the requested point; shape picks bowl, hill, slope or noise
  function automatic longint objective(longint x, longint m, int shape, longint off);
    longint d;
    d = sat_sub(x, m);
    case (shape)
      0: return sat_add(fx_mul(d, d), off);
      1: return sat_sub(off, fx_mul(d, d));
      2: return sat_add(fx_mul(d, 64'sd40000), off);
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  int items_sent = 0;

  // one well-formed search, cut short now and then by a restart or noise
  task automatic run_search();
    longint m, a, b, off;
    int shape, span, n;
    span = $urandom_range(4, 24);
    m = longint'($signed($urandom())) >>> $urandom_range(4, 14);
    a = clamp_word(m + (longint'($signed($urandom())) >>> span));
    b = clamp_word(a + (longint'($signed($urandom())) >>> (span + 2)));
    off = longint'($signed($urandom())) >>> $urandom_range(2, 20);
    shape = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
    send_word(start_word(a, b));
    items_sent++;
    n = 0;
    while (sb.ph != PH_IDLE && n < 40) begin
      if ($urandom_range(0, 49) == 0) break;  // abandon; next start restarts
      send_word(value_word(objective(sb.next_x, m, shape, off)));
      items_sent++;
      n++;
    end
    if ($urandom_range(0, 7) == 0) begin
      // noise word: any op, any bits
      send_word(($urandom_range(0, 1) == 0) ?
                start_word($signed($urandom()), $signed($urandom())) :
                value_word($signed($urandom())));
      items_sent++;
    end
  endtask

  task automatic random_phase(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) run_search();
  endtask

  int waited;

  initial begin
    sb = new();
    sb.clear_state();
    sb.gold = GOLD_RST;
    sb.growth = GROWTH_RST;
    sb.dfloor = FLOOR_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray value while idle, extremes, restart mid-search
    send_word(value_word(WMAX));
    send_word(start_word(WMIN, WMAX));
    send_word(value_word(WMIN));
    send_word(value_word(WMAX));
    send_word(value_word(0));
    send_word(start_word(WMAX, WMIN));            // restart drops the old search
    send_word(value_word(WMAX));
    send_word(value_word(WMIN));
    send_word(value_word(WMIN));
    send_word(start_word(0, 0));                  // both points equal
    repeat (4) send_word(value_word(0));
    send_word(start_word(64'sd65536, 64'sd131072)); // downhill on the far side
    send_word(value_word(64'sd100));
    send_word(value_word(64'sd200));
    repeat (5) send_word(value_word(sb.next_x >>> 4));
    items_sent = 24;

    // reset settings, no idling on either side
    gaps_on = 1'b0;
    stall_pct = 0;
    random_phase(300);

    // zero floor, both sides idling
    wait_idle();
    write_reg(ADDR_FLOOR, 0);
    gaps_on = 1'b1;
    stall_pct = 30;
    random_phase(300);

    // lower extremes
    wait_idle();
    write_reg(ADDR_GOLD, 0);
    write_reg(ADDR_GROWTH, 0);
    write_reg(ADDR_FLOOR, 64'd1);
    stall_pct = 60;
    random_phase(250);

    // upper extremes
    wait_idle();
    write_reg(ADDR_GOLD, 64'h3FFFF);
    write_reg(ADDR_GROWTH, 64'h7FFFFFFF);
    write_reg(ADDR_FLOOR, 64'hFFFF);
    gaps_on = 1'b0;
    stall_pct = 10;
    random_phase(250);

    // random settings, mixed idling
    repeat (4) begin
      wait_idle();
      write_reg(ADDR_GOLD, $urandom_range(0, 262143));
      write_reg(ADDR_GROWTH, $urandom_range(0, 32'h7FFFFFFF));
      write_reg(ADDR_FLOOR, $urandom_range(0, 65535));
      gaps_on = $urandom_range(0, 1);
      stall_pct = $urandom_range(0, 50);
      random_phase(100);
    end

    // drain and settle, bounded
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < STALL_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, sb.pending.size());
      sb.errors++;
    end

    $display("Ran %0d input words and checked %0d result words (%0d finished brackets)",
             sb.words_in, sb.words_out, sb.brackets);
    $display("across reset, zero-floor, extreme and random register settings.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
